/* hw/rtl/sstf_pkg.sv */
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int CYL_W  = 16;
    localparam int ADDR_W = 32;
    localparam int PID_W  = 16;
    localparam int CNT_W  = 5;

    // op codes of an input item
    typedef enum logic {
        OP_ARRIVE   = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   new_request_id;
        logic [TIME_W-1:0] new_arrival_time;
        logic [CYL_W-1:0]  new_cylinder;
        logic [ADDR_W-1:0] new_address;
        logic [PID_W-1:0]  new_process_id;
        logic [CYL_W-1:0]  head_cylinder;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   run_request_id;
        logic [TIME_W-1:0] run_arrival_time;
        logic [CYL_W-1:0]  run_cylinder;
        logic [ADDR_W-1:0] run_address;
        logic [PID_W-1:0]  run_process_id;
        logic [CNT_W-1:0]  waiting_count;
        logic              dropped;
    } out_item_t;

    // one request, as held in the queue and in the running slot
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [CYL_W-1:0]  cylinder;
        logic [ADDR_W-1:0] address;
        logic [PID_W-1:0]  process;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic arrive;          // accept arrival item
        logic complete_empty;  // accept completion, queue empty
        logic scan_start;      // accept completion, queue not empty
        logic scan;            // scan step, one entry
        logic select;          // move best entry to running slot
        logic shift;           // compaction step, one entry
        logic publish;         // load output register
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic fill_zero;
        logic scan_last;
        logic shift_done;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/sstf_ram.sv */
`timescale 1ns / 1ps

module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/sstf_ctrl.sv */
`timescale 1ns / 1ps

module sstf_ctrl
    import sstf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.op == OP_ARRIVE)
                    begin
                        cmd.arrive = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else if (status.fill_zero)
                    begin
                        cmd.complete_empty = 1'b1;
                        state_next         = ST_RESULT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (status.shift_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/sstf_datapath.sv */
`timescale 1ns / 1ps

module sstf_datapath
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // running request
    entry_t              run_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                drop_reg;
    logic [CYL_W-1:0]    head_reg;

    // scan / compaction pipeline
    logic [FILL_W-1:0]   rd_cnt_reg;
    logic [FILL_W-1:0]   wr_cnt_reg;
    logic                pipe_valid_reg;
    logic [FILL_W-1:0]   pipe_idx_reg;
    logic [FILL_W-1:0]   best_idx_reg;
    logic [CYL_W-1:0]    best_dist_reg;
    entry_t              best_entry_reg;

    out_item_t           out_reg;
    logic                out_valid_reg;

    entry_t              rd_entry;
    entry_t              new_entry;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_waddr;
    logic                ram_we;
    logic                queue_write;
    logic                rd_more;
    logic [CYL_W-1:0]    seek_dist;
    logic                take;
    logic [FILL_W+4:0]   fill_ext;

    assign rd_entry  = entry_t'(ram_rdata);
    assign new_entry = '{id:       in_data.new_request_id,
                         arrival:  in_data.new_arrival_time,
                         cylinder: in_data.new_cylinder,
                         address:  in_data.new_address,
                         process:  in_data.new_process_id};

    assign queue_write = cmd.arrive && (run_reg.process != '0)
                         && (fill_reg < FILL_W'(QUEUE_DEPTH));
    assign ram_we      = queue_write || (cmd.shift && pipe_valid_reg);
    assign ram_waddr   = queue_write ? fill_reg[IDX_W-1:0] : wr_cnt_reg[IDX_W-1:0];
    assign ram_wdata   = queue_write ? ENTRY_W'(new_entry) : ram_rdata;

    sstf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_more   = (rd_cnt_reg < fill_reg);
    assign seek_dist = (head_reg > rd_entry.cylinder) ? (head_reg - rd_entry.cylinder)
                                                      : (rd_entry.cylinder - head_reg);
    // first entry always taken; ties go to earlier arrival, then lower slot
    assign take    = (pipe_idx_reg == '0) || (seek_dist < best_dist_reg)
                     || ((seek_dist == best_dist_reg)
                         && (rd_entry.arrival < best_entry_reg.arrival));

    assign status.op         = in_data.op;
    assign status.fill_zero  = (fill_reg == '0);
    assign status.scan_last  = pipe_valid_reg
                               && (FILL_W'(pipe_idx_reg + FILL_W'(1)) == fill_reg);
    assign status.shift_done = !rd_more && !pipe_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign fill_ext  = (FILL_W + 5)'(fill_reg);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.arrive)
            begin
                if (run_reg.process == '0)
                begin
                    run_reg <= new_entry;
                end
                else if (queue_write)
                begin
                    fill_reg <= FILL_W'(fill_reg + FILL_W'(1));
                end
            end
            if (cmd.complete_empty)
            begin
                run_reg <= '0;
            end
            if (cmd.select)
            begin
                run_reg <= best_entry_reg;
            end
            if (cmd.shift && status.shift_done)
            begin
                fill_reg <= FILL_W'(fill_reg - FILL_W'(1));
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arrive)
        begin
            drop_reg <= (run_reg.process != '0) && !queue_write;
        end
        if (cmd.complete_empty || cmd.scan_start)
        begin
            drop_reg <= 1'b0;
        end
        if (cmd.scan_start)
        begin
            head_reg       <= in_data.head_cylinder;
            rd_cnt_reg     <= '0;
            pipe_valid_reg <= 1'b0;
        end
        if (cmd.scan || cmd.shift)
        begin
            if (rd_more)
            begin
                rd_cnt_reg <= FILL_W'(rd_cnt_reg + FILL_W'(1));
            end
            pipe_valid_reg <= rd_more;
            pipe_idx_reg   <= rd_cnt_reg;
        end
        if (cmd.scan && pipe_valid_reg && take)
        begin
            best_idx_reg   <= pipe_idx_reg;
            best_dist_reg  <= seek_dist;
            best_entry_reg <= rd_entry;
        end
        if (cmd.select)
        begin
            rd_cnt_reg     <= FILL_W'(best_idx_reg + FILL_W'(1));
            wr_cnt_reg     <= best_idx_reg;
            pipe_valid_reg <= 1'b0;
        end
        if (cmd.shift && pipe_valid_reg)
        begin
            wr_cnt_reg <= FILL_W'(wr_cnt_reg + FILL_W'(1));
        end
        if (cmd.publish)
        begin
            out_reg.run_request_id   <= run_reg.id;
            out_reg.run_arrival_time <= run_reg.arrival;
            out_reg.run_cylinder     <= run_reg.cylinder;
            out_reg.run_address      <= run_reg.address;
            out_reg.run_process_id   <= run_reg.process;
            out_reg.waiting_count    <= fill_ext[CNT_W-1:0];
            out_reg.dropped          <= drop_reg;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            (fill_reg == FILL_W'($past(fill_reg) + FILL_W'(1))
             || fill_reg == FILL_W'($past(fill_reg) - FILL_W'(1))))
        else $error("queue fill moved by more than one");

    a_select_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.select |-> (best_idx_reg < fill_reg))
        else $error("selected slot outside queue");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && pipe_valid_reg) |-> (FILL_W'(wr_cnt_reg + FILL_W'(1)) < fill_reg))
        else $error("compaction write past queue tail");
`endif

endmodule

/* hw/rtl/sstf_disk_request_scheduler.sv */
`timescale 1ns / 1ps

// Shortest-seek-time-first disk request scheduler.
// Input channel (in_valid/in_ready/in_data) carries one item: op 0 is a
// request arrival, op 1 reports that the running request completed and
// gives the head cylinder. Output channel (out_valid/out_ready/out_data)
// returns one item per input item: the running request after the step,
// the number of queued requests and a flag for an arrival dropped on a
// full queue.
// An arrival or a completion on an empty queue goes straight to the
// result state; out_valid rises once the output register is free. A
// completion with requests queued scans the queue (one entry per
// cycle, one read port, registered read), selects the nearest entry,
// compacts the entries behind it and then publishes the result.
// One item is in work at a time; in_ready is high only while idle, so the
// next item can be taken the cycle after its predecessor's result is loaded.
// Reset clears the running slot (idle) and empties the queue; the queue
// RAM itself is not cleared, only slots below the fill count are read.
// A stalled receiver holds the result in the output register; the next
// item is still accepted, and its result waits until the register frees.
module sstf_disk_request_scheduler
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accept, scan, select, compact, publish
    sstf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // running slot, queue RAM, nearest-cylinder compare, output register
    sstf_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* dv/sstf_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the SSTF scheduler, keeps its own copy of the
// running slot and the waiting queue, and compares every result item.
module sstf_checker
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    localparam int PRINT_CAP = 100;

    entry_t    waiting [QUEUE_DEPTH];
    int        fill;
    entry_t    running;
    out_item_t expected_runs [$];
    out_item_t want;

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            note_mismatch($sformatf("%s got %0h, expected %0h", field, got, exp_val));
    endtask

    // One step of the scheduler: updates the local state, returns the result.
    function automatic out_item_t advance_schedule(input in_item_t it);
        out_item_t res;
        entry_t    incoming;
        int        best;
        int        best_dist;
        int        seek;
        logic      drop;
        drop = 1'b0;
        if (it.op == OP_ARRIVE) begin
            incoming.id       = it.new_request_id;
            incoming.arrival  = it.new_arrival_time;
            incoming.cylinder = it.new_cylinder;
            incoming.address  = it.new_address;
            incoming.process  = it.new_process_id;
            if (running.process == '0) begin
                running = incoming;
            end
            else if (fill < QUEUE_DEPTH) begin
                waiting[fill] = incoming;
                fill++;
            end
            else begin
                drop = 1'b1;
            end
        end
        else if (fill == 0) begin
            running = '0;
        end
        else begin
            best      = 0;
            best_dist = 0;
            for (int i = 0; i < fill; i++) begin
                seek = (it.head_cylinder > waiting[i].cylinder)
                     ? int'(it.head_cylinder) - int'(waiting[i].cylinder)
                     : int'(waiting[i].cylinder) - int'(it.head_cylinder);
                // nearest wins; equal distance goes to the earlier arrival,
                // then to the lower queue slot
                if (i == 0 || seek < best_dist ||
                    (seek == best_dist && waiting[i].arrival < waiting[best].arrival))
                begin
                    best      = i;
                    best_dist = seek;
                end
            end
            running = waiting[best];
            for (int i = best; i + 1 < fill; i++)
                waiting[i] = waiting[i + 1];
            fill--;
        end
        res.run_request_id   = running.id;
        res.run_arrival_time = running.arrival;
        res.run_cylinder     = running.cylinder;
        res.run_address      = running.address;
        res.run_process_id   = running.process;
        res.waiting_count    = CNT_W'(fill);
        res.dropped          = drop;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill       = 0;
            running    = '0;
            fail_count = 0;
            expected_runs.delete();
            pending    = 0;
        end
        else begin
            // results first: a result never belongs to an item taken this edge
            if (out_valid && out_ready) begin
                if (expected_runs.size() == 0) begin
                    note_mismatch("result item with no item outstanding");
                end
                else begin
                    want = expected_runs.pop_front();
                    compare_field("run_request_id", 32'(out_data.run_request_id),
                                  32'(want.run_request_id));
                    compare_field("run_arrival_time", out_data.run_arrival_time,
                                  want.run_arrival_time);
                    compare_field("run_cylinder", 32'(out_data.run_cylinder),
                                  32'(want.run_cylinder));
                    compare_field("run_address", out_data.run_address,
                                  want.run_address);
                    compare_field("run_process_id", 32'(out_data.run_process_id),
                                  32'(want.run_process_id));
                    compare_field("waiting_count", 32'(out_data.waiting_count),
                                  32'(want.waiting_count));
                    compare_field("dropped", 32'(out_data.dropped), 32'(want.dropped));
                end
            end
            if (in_valid && in_ready)
                expected_runs.push_back(advance_schedule(in_data));
            pending = expected_runs.size();
        end
    end

endmodule

/* dv/tb_sstf_disk_request_scheduler.sv */
`timescale 1ns / 1ps

module tb_sstf_disk_request_scheduler;
    import sstf_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int BLOCK_ITEMS  = 100;
    // receiver hold-off used to back the block up
    localparam int HOLD_CYCLES  = 400;
    // cycles without any handshake before the run is declared hung;
    // well above the hold-off plus a full-queue completion
    localparam int STALL_LIMIT  = 4000;
    // tail wait, longer than a completion on a full queue
    localparam int TAIL_CYCLES  = 80;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int        fail_count;
    int        pending;
    int        quiet_cycles;

    // idling switches for each side, and the receiver hold-off request
    bit        tx_idle_on;
    bit        rx_idle_on;
    bit        hold_req;

    // directed fill of the queue: cylinders and arrival times set up so that
    // both tie-break rules and the cylinder extremes get exercised
    logic [CYL_W-1:0]  fill_cyl  [QUEUE_DEPTH];
    logic [TIME_W-1:0] fill_time [QUEUE_DEPTH];

    sstf_disk_request_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    sstf_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_sched_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hang detection: any accepted item on either side resets the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: ready most cycles, drops out ~6% when idling is on; a hold
    // request keeps it low for a long stretch so the block backs up
    initial begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                out_ready <= !(rx_idle_on && $urandom_range(99) < 6);
            end
        end
    end

    function automatic in_item_t arrival_item(input logic [ID_W-1:0] id,
                                              input logic [TIME_W-1:0] arrival,
                                              input logic [CYL_W-1:0] cyl,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [PID_W-1:0] pid);
        in_item_t it;
        it                  = '0;
        it.op               = OP_ARRIVE;
        it.new_request_id   = id;
        it.new_arrival_time = arrival;
        it.new_cylinder     = cyl;
        it.new_address      = addr;
        it.new_process_id   = pid;
        return it;
    endfunction

    function automatic in_item_t completion_item(input logic [CYL_W-1:0] head);
        in_item_t it;
        it               = '0;
        it.op            = OP_COMPLETE;
        it.head_cylinder = head;
        return it;
    endfunction

    // a quarter near one spot so distances tie, a quarter at the extremes, the rest anywhere
    function automatic logic [CYL_W-1:0] pick_cylinder();
        case ($urandom_range(3))
            0:       return CYL_W'(990 + $urandom_range(20));
            1:       return $urandom_range(1) ? '1 : '0;
            default: return CYL_W'($urandom);
        endcase
    endfunction

    // Offer one item; valid stays high from the previous item unless an idle
    // cycle is inserted, so valid is never lowered and raised in one step.
    task automatic send_item(input in_item_t it);
        while (tx_idle_on && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // sender rests until the checker holds no more expectations
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        in_item_t item;
        int       arrive_pct;

        in_valid   <= 1'b0;
        in_data    <= '0;
        rst_n      <= 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;

        fill_cyl  = '{900, 1100, 1100, 0, 16'hFFFF, 2000, 1000, 5,
                      40000, 1001, 999, 1000, 300, 16'hFFFE, 1, 7};
        fill_time = '{50, 20, 20, 32'hFFFF_FFFF, 0, 9, 3, 1,
                      2, 30, 10, 3, 4, 5, 6, 32'h8000_0000};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // completion while idle on an empty queue: all zeros
        send_item(completion_item(16'd1234));
        // idle arrival with a null process: runs, but the block stays idle
        send_item(arrival_item(16'd1, 32'd1, 16'd1, 32'd1, '0));
        // so the next arrival replaces it; all fields at their top values
        send_item(arrival_item('1, '1, '1, '1, '1));
        // fill the queue to the brim
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(arrival_item(ID_W'(100 + i), fill_time[i], fill_cyl[i],
                                   ADDR_W'(32'hA000_0000 + i), PID_W'(i)));
        // one more arrival on a full queue is dropped
        send_item(arrival_item(16'hDEAD, 32'd0, 16'd1000, '0, 16'd7));
        // head at 1000: two entries on 1000 with equal arrival, lower slot wins
        send_item(completion_item(16'd1000));
        send_item(completion_item(16'd1000));
        // 999 and 1001 tie on distance; 999 arrived earlier from a later slot
        send_item(completion_item(16'd1000));
        send_item(completion_item(16'd1000));
        // head at the cylinder extremes
        send_item(completion_item('0));
        send_item(completion_item('1));
        // two entries on 1100, same arrival: lower slot wins
        send_item(completion_item(16'd1100));

        // ---- random part ----
        // blocks cycle through arrival mixes that fill and drain the queue
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            // blocks 5..7 run with no idling on either side
            tx_idle_on = !(blk >= 5 && blk <= 7);
            rx_idle_on = tx_idle_on;
            case (blk % 4)
                0:       arrive_pct = 80;
                1:       arrive_pct = 45;
                2:       arrive_pct = 25;
                default: arrive_pct = 55;
            endcase
            if (blk == 3) begin
                // receiver holds off while arrivals keep coming
                hold_req   = 1'b1;
                arrive_pct = 90;
            end
            if (blk == 9)
                wait_drained();
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                item.op = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_COMPLETE;
                item.new_request_id   = ID_W'($urandom);
                item.new_arrival_time = $urandom_range(1) ? TIME_W'($urandom_range(7))
                                                          : TIME_W'($urandom);
                item.new_cylinder     = pick_cylinder();
                item.new_address      = ADDR_W'($urandom);
                item.new_process_id   = ($urandom_range(9) == 0) ? '0 : PID_W'($urandom);
                item.head_cylinder    = pick_cylinder();
                send_item(item);
            end
        end

        // ---- wind down ----
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_ram.sv
hw/rtl/sstf_ctrl.sv
hw/rtl/sstf_datapath.sv
hw/rtl/sstf_disk_request_scheduler.sv
dv/sstf_checker.sv
dv/tb_sstf_disk_request_scheduler.sv
